// File: hw/rtl/bha_pkg.sv
// Package: constants, types and helpers for the buddy heap allocator
`default_nettype none
package bha_pkg;
  localparam int HEAP_UNITS_DEF   = 4096;
  localparam int UNIT_BYTES_DEF   = 256;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int ADDR_W  = 48;
  localparam int ORD_W   = 4;
  localparam int BYTES_W = 24;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_ZERO   = 2'd2,
    ST_BADADR = 2'd3
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_ORDER = 1'b1;

  // Result handed from the sequencer to the output stage
  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   addr;
  } result_t;
endpackage
`default_nettype wire

// File: hw/rtl/buddy_heap_allocator.sv
// Top level: buddy heap allocator with sequencer around one header store
// Free: walks block headers from unit 0, block by block (search for a block start).
// Allocate: each scan visits every block (read, then merge check read of the buddy);
// a miss adds merge passes and a rescan, then splitting halves the block one order at a time.
// One item at a time, not ready meanwhile.
// Reset (and every register write) makes the heap one free block in unit 0;
// other header entries are only read after being written.
`default_nettype none
module buddy_heap_allocator
  import bha_pkg::*;
#(
  parameter int HEAP_UNITS   = HEAP_UNITS_DEF,
  parameter int UNIT_BYTES   = UNIT_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [ADDR_W-1:0]   cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                opcode,
  input  wire logic [BYTES_W-1:0]  request_bytes,
  input  wire logic [ADDR_W-1:0]   block_address,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               status,
  output logic [ADDR_W-1:0]        result_address
);
  localparam int IDX_W  = (HEAP_UNITS > 1) ? $clog2(HEAP_UNITS) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int MAXORD = $clog2(HEAP_UNITS + 1) - 1;
  localparam int UB_SH  = $clog2(UNIT_BYTES);
  localparam int K_W    = 6;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SRD    = 11'b00000000010, // read header at u
    S_SCUR   = 11'b00000000100, // header of u available
    S_SNXT   = 11'b00000001000, // header of buddy available
    S_SEND   = 11'b00000010000, // end of a walk
    S_SPLIT  = 11'b00000100000,
    S_FRD    = 11'b00001000000,
    S_FCUR   = 11'b00010000000,
    S_DONE   = 11'b00100000000,
    S_SWAIT  = 11'b01000000000, // wait for header read at u
    S_FWAIT  = 11'b10000000000
  } state_t;

  state_t state;
  logic [ADDR_W-1:0] heap_base;
  logic [ORD_W-1:0]  heap_order;
  logic [K_W-1:0]    need_k;
  logic [IDX_W-1:0]  target;
  logic              target_ok;
  logic [CNT_W-1:0]  u;
  logic [ORD_W-1:0]  cur_o;
  logic              cur_f;
  logic              found;
  logic [ORD_W-1:0]  best_o;
  logic [IDX_W-1:0]  pick;
  logic [1:0]        phase;   // 0 first scan, 1 merge pass, 2 rescan
  logic              any_merge;
  logic [ORD_W-1:0]  split_o;
  result_t           res;
  logic              res_valid;

  // Effective heap order, saturated at the store size
  logic [ORD_W-1:0] eff_ord;
  assign eff_ord = (int'(heap_order) > MAXORD) ? ORD_W'(MAXORD) : heap_order;
  logic [CNT_W-1:0] lim;
  assign lim = CNT_W'(1) << eff_ord;

  // Store port
  logic             t_we;
  logic [IDX_W-1:0] t_waddr;
  logic [ORD_W-1:0] t_word;
  logic             t_wfree;
  logic [IDX_W-1:0] t_raddr;
  logic [ORD_W-1:0] t_rord;
  logic             t_rfree;

  bha_table #(.UNITS(HEAP_UNITS), .IDX_W(IDX_W)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata_order(t_word),
    .wdata_free(t_wfree), .raddr(t_raddr), .rdata_order(t_rord), .rdata_free(t_rfree)
  );

  // Request decode: unit count and needed order
  logic [BYTES_W:0] units_c;
  logic [K_W-1:0]   k_c;
  always_comb begin
    if (request_bytes <= BYTES_W'(UNIT_BYTES)) begin
      units_c = (BYTES_W+1)'(1);
    end else begin
      units_c = ((BYTES_W+1)'(request_bytes) + (BYTES_W+1)'(HEADER_BYTES + UNIT_BYTES - 1))
                >> UB_SH;
    end
    k_c = '0;
    for (int i = BYTES_W; i >= 0; i--) begin
      if (units_c > ((BYTES_W+1)'(1) << i)) begin
        if (k_c == '0) k_c = K_W'(i + 1);
      end
    end
  end

  // Free address decode
  logic [ADDR_W-1:0] lo_addr, rel_addr;
  logic              free_ok_c;
  assign lo_addr  = heap_base + ADDR_W'(HEADER_BYTES);
  assign rel_addr = block_address - lo_addr;
  always_comb begin
    free_ok_c = ({1'b0, block_address} >= ({1'b0, heap_base} + (ADDR_W+1)'(HEADER_BYTES)))
              && (rel_addr[UB_SH-1:0] == '0)
              && ((rel_addr >> UB_SH) < ADDR_W'(lim));
  end

  // Merge condition at u with buddy n (current header registered in cur_o/cur_f)
  logic [CNT_W-1:0] nxt_u;
  logic             can_pair;
  assign nxt_u    = u + (CNT_W'(1) << cur_o);
  assign can_pair = (nxt_u < lim) && (((u >> cur_o) & CNT_W'(1)) == '0) && cur_f;

  // A register write takes the idle cycle, so no item beat is taken alongside it
  assign in_ready  = (state == S_IDLE) && !res_valid && !cfg_valid;
  assign cfg_ready = (state == S_IDLE) && !res_valid;
  assign out_valid = res_valid;
  assign status    = res.status;
  assign result_address = res.addr;

  logic             mrg;
  logic [ORD_W-1:0] o_now;
  assign mrg   = (t_rfree && (t_rord == cur_o));
  assign o_now = mrg ? cur_o + ORD_W'(1) : cur_o;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      heap_base  <= '0;
      heap_order <= ORD_W'(12);
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && out_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            case (cfg_index[0])
              CFG_BASE:  heap_base  <= cfg_data;
              CFG_ORDER: heap_order <= cfg_data[ORD_W-1:0];
              default: ;
            endcase
          end else if (in_valid && in_ready) begin
            need_k     <= k_c;
            target     <= IDX_W'(rel_addr >> UB_SH);
            target_ok  <= free_ok_c;
            u          <= '0;
            found      <= 1'b0;
            phase      <= 2'd0;
            any_merge  <= 1'b0;
            if (opcode == OP_FREE) begin
              state <= S_FRD;
            end else if (request_bytes == '0) begin
              res.status <= ST_ZERO;
              res.addr   <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_SRD;
            end
          end
        end
        S_SRD: begin
          state <= S_SWAIT;
        end
        S_SWAIT: begin
          cur_o <= t_rord;
          cur_f <= t_rfree;
          state <= S_SCUR;
        end
        S_SCUR: begin
          if (can_pair) begin
            state <= S_SNXT;  // buddy read issued this cycle
          end else begin
            if (phase != 2'd1 && cur_f && (K_W'(cur_o) >= need_k)
                && (!found || cur_o < best_o)) begin
              found <= 1'b1; best_o <= cur_o; pick <= IDX_W'(u);
            end
            u <= nxt_u;
            state <= (nxt_u >= lim) ? S_SEND : S_SRD;
          end
        end
        S_SNXT: begin
          if (mrg) any_merge <= 1'b1;
          if (phase != 2'd1 && (K_W'(o_now) >= need_k) && (!found || o_now < best_o)) begin
            found <= 1'b1; best_o <= o_now; pick <= IDX_W'(u);
          end
          u <= u + (CNT_W'(1) << o_now);
          state <= ((u + (CNT_W'(1) << o_now)) >= lim) ? S_SEND : S_SRD;
        end
        S_SEND: begin
          u <= '0;
          any_merge <= 1'b0;
          if (phase != 2'd1 && found) begin
            split_o <= best_o;
            state   <= S_SPLIT;
          end else if (phase == 2'd0) begin
            phase <= 2'd1; state <= S_SRD;
          end else if (phase == 2'd1) begin
            if (!any_merge) phase <= 2'd2;
            state <= S_SRD;
          end else begin
            res.status <= ST_NOFIT; res.addr <= '0; state <= S_DONE;
          end
        end
        S_SPLIT: begin
          if (K_W'(split_o) > need_k) begin
            split_o <= split_o - ORD_W'(1);
          end else begin
            res.status <= ST_OK;
            res.addr   <= heap_base + (ADDR_W'(pick) << UB_SH) + ADDR_W'(HEADER_BYTES);
            state      <= S_DONE;
          end
        end
        S_FRD: begin
          if (!target_ok || u > CNT_W'(target) || u >= lim) begin
            res.status <= ST_BADADR; res.addr <= '0; state <= S_DONE;
          end else begin
            state <= S_FWAIT;
          end
        end
        S_FWAIT: begin
          state <= S_FCUR;
        end
        S_FCUR: begin
          if (u == CNT_W'(target)) begin
            res.status <= ST_OK; res.addr <= '0; state <= S_DONE;
          end else begin
            u <= u + (CNT_W'(1) << t_rord);
            state <= S_FRD;
          end
        end
        S_DONE: begin
          if (!res_valid) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Store port steering
  always_comb begin
    t_we    = 1'b0;
    t_waddr = IDX_W'(u);
    t_word  = cur_o;
    t_wfree = cur_f;
    t_raddr = IDX_W'(u);
    if (rst || (state == S_IDLE && cfg_valid && cfg_ready)) begin
      t_we    = 1'b1;
      t_waddr = '0;
      t_wfree = 1'b1;
      t_word  = rst ? ORD_W'(MAXORD < 12 ? MAXORD : 12)
              : (cfg_index[0] == CFG_ORDER
                 ? ((int'(cfg_data[ORD_W-1:0]) > MAXORD) ? ORD_W'(MAXORD)
                    : cfg_data[ORD_W-1:0])
                 : eff_ord);
    end else begin
      case (state)
        S_SCUR: t_raddr = IDX_W'(nxt_u);
        S_SNXT: begin
          t_we = mrg; t_waddr = IDX_W'(u); t_word = o_now; t_wfree = 1'b1;
        end
        S_SPLIT: begin
          t_we = 1'b1;
          if (K_W'(split_o) > need_k) begin
            t_waddr = pick + (IDX_W'(1) << (split_o - ORD_W'(1)));
            t_word  = split_o - ORD_W'(1);
            t_wfree = 1'b1;
          end else begin
            t_waddr = pick; t_word = split_o; t_wfree = 1'b0;
          end
        end
        S_FCUR: begin
          t_we = (u == CNT_W'(target)); t_waddr = target; t_word = t_rord; t_wfree = 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_one_hot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_done_res: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !res_valid) |=> res_valid) else $error("result lost");
  a_free_addr: assert property (@(posedge clk) disable iff (rst)
    (res_valid && $rose(res_valid) && res.status != ST_OK) |-> res.addr == '0)
    else $error("error result carries address");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/bha_table.sv
// Block header store: order and free bit for every unit, one write port, one registered read port
`default_nettype none
module bha_table
  import bha_pkg::*;
#(
  parameter int UNITS = HEAP_UNITS_DEF,
  parameter int IDX_W = (UNITS > 1) ? $clog2(UNITS) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire logic [ORD_W-1:0] wdata_order,
  input  wire logic             wdata_free,
  input  wire logic [IDX_W-1:0] raddr,
  output logic      [ORD_W-1:0] rdata_order,
  output logic                  rdata_free
);
  logic [ORD_W:0] mem [UNITS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wdata_order, wdata_free};
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    {rdata_order, rdata_free} <= mem[raddr];
  end
endmodule
`default_nettype wire
